[design/fwvs_pkg.sv]
// Shared types, request and status codes for the FIFO with value swap.
`default_nettype none

package fwvs_pkg;

    localparam int FWVS_DEPTH   = 16;
    localparam int DATA_W       = 8;
    localparam int OCC_W        = 5;

    localparam logic [1:0] OP_ENQUEUE   = 2'd0;
    localparam logic [1:0] OP_DEQUEUE   = 2'd1;
    localparam logic [1:0] OP_SWAP      = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] first_key;
        logic [DATA_W-1:0] second_key;
    } fwvs_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] removed_value;
        logic [OCC_W-1:0]  occupancy;
    } fwvs_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       write_tail;
        logic       read_head;
        logic       take_head;
        logic       scan_start;
        logic       scan_cmp;
        logic       scan_step;
        logic       write_a;
        logic       write_b;
        logic       set_status;
        logic [1:0] status_code;
        logic       load_out;
    } fwvs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] operation;
        logic       full;
        logic       empty;
        logic       scan_last;
        logic       found_both;
        logic       out_free;
    } fwvs_stat_t;

endpackage

`default_nettype wire

[design/fwvs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fwvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/fwvs_ctrl.sv]
// Controller state machine: sequences enqueue, dequeue and swap requests.
`default_nettype none

module fwvs_ctrl
    import fwvs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire fwvs_stat_t stat,
    output fwvs_cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_DEQ_DATA = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_SCAN_END = 7'b0010000,
        S_WRITE_B  = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_FINISH;
                case (stat.operation)
                    OP_ENQUEUE: begin
                        if (stat.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end else begin
                            cmd.write_tail = 1'b1;
                        end
                    end
                    OP_DEQUEUE: begin
                        if (stat.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end else begin
                            cmd.read_head = 1'b1;
                            state_next    = S_DEQ_DATA;
                        end
                    end
                    OP_SWAP: begin
                        if (stat.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default: begin
                        // unused code: report ok, change nothing
                    end
                endcase
            end
            S_DEQ_DATA: begin
                cmd.take_head = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN: begin
                cmd.scan_cmp = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_SCAN_END;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SCAN_END: begin
                if (stat.found_both) begin
                    cmd.write_a = 1'b1;
                    state_next  = S_WRITE_B;
                end else begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end
            S_WRITE_B: begin
                cmd.write_b = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/fwvs_datapath.sv]
// Datapath: ring pointers, entry store, swap scan and result register.
`default_nettype none

module fwvs_datapath
    import fwvs_pkg::*;
#(
    parameter int DEPTH = FWVS_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fwvs_in_t  s_payload,
    input  wire fwvs_cmd_t cmd,
    output fwvs_stat_t     stat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output fwvs_out_t      m_payload
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    fwvs_in_t          req_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     rd_pos_reg, rd_pos_next;
    logic [CW-1:0]     scan_left_reg, scan_left_next;
    logic              found_a_reg, found_a_next;
    logic              found_b_reg, found_b_next;
    logic [AW-1:0]     pos_a_reg, pos_a_next;
    logic [AW-1:0]     pos_b_reg, pos_b_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] removed_reg, removed_next;
    fwvs_out_t         out_reg;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic [CW+OCC_W-1:0] occ_ext;

    fwvs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // The matched entry equals its key, so the exchange writes each key over the other.
    always_comb begin
        ram_we    = cmd.write_tail | cmd.write_a | cmd.write_b;
        ram_waddr = cmd.write_a ? pos_a_reg : (cmd.write_b ? pos_b_reg : tail_reg);
        ram_wdata = cmd.write_a ? req_reg.second_key :
                    (cmd.write_b ? req_reg.first_key : req_reg.value);
        ram_re    = cmd.read_head | cmd.scan_start | cmd.scan_step;
        ram_raddr = cmd.scan_step ? ring_next(rd_pos_reg) : head_reg;
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rd_pos_next    = rd_pos_reg;
        scan_left_next = scan_left_reg;
        found_a_next   = found_a_reg;
        found_b_next   = found_b_reg;
        pos_a_next     = pos_a_reg;
        pos_b_next     = pos_b_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        out_valid_next = out_valid_reg & ~m_ready;

        if (cmd.load_req) begin
            status_next  = ST_OK;
            removed_next = '0;
        end
        if (cmd.set_status) begin
            status_next = cmd.status_code;
        end
        if (cmd.write_tail) begin
            tail_next  = ring_next(tail_reg);
            count_next = count_reg + CW'(1);
        end
        if (cmd.take_head) begin
            removed_next = ram_rdata;
            head_next    = ring_next(head_reg);
            count_next   = count_reg - CW'(1);
        end
        if (cmd.scan_start) begin
            rd_pos_next    = head_reg;
            scan_left_next = count_reg - CW'(1);
            found_a_next   = 1'b0;
            found_b_next   = 1'b0;
        end
        if (cmd.scan_cmp) begin
            if (ram_rdata == req_reg.first_key) begin
                found_a_next = 1'b1;
                pos_a_next   = rd_pos_reg;
            end
            if (ram_rdata == req_reg.second_key) begin
                found_b_next = 1'b1;
                pos_b_next   = rd_pos_reg;
            end
        end
        if (cmd.scan_step) begin
            rd_pos_next    = ring_next(rd_pos_reg);
            scan_left_next = scan_left_reg - CW'(1);
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_payload;
        end
        rd_pos_reg    <= rd_pos_next;
        scan_left_reg <= scan_left_next;
        found_a_reg   <= found_a_next;
        found_b_reg   <= found_b_next;
        pos_a_reg     <= pos_a_next;
        pos_b_reg     <= pos_b_next;
        status_reg    <= status_next;
        removed_reg   <= removed_next;
        if (cmd.load_out) begin
            out_reg.status        <= status_reg;
            out_reg.removed_value <= removed_reg;
            out_reg.occupancy     <= occ_ext[OCC_W-1:0];
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    assign stat.operation  = req_reg.operation;
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = (scan_left_reg == '0);
    assign stat.found_both = found_a_reg & found_b_reg;
    assign stat.out_free   = ~out_valid_reg | m_ready;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_tail |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not advance the count");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result loaded over a pending transfer");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.write_tail && cmd.take_head))
        else $error("enqueue and dequeue in one cycle");

endmodule

`default_nettype wire

[design/fifo_with_value_swap_unit.sv]
// Top level of the FIFO with value swap: controller plus datapath.
// Usage:
//   The input channel (s_valid, s_ready, s_payload) carries one request per
//   transfer: enqueue a byte, dequeue the head byte, or swap the last entries
//   matching two keys. Every request yields exactly one result transfer on
//   the output channel (m_valid, m_ready, m_payload) with a status, the byte
//   removed by a successful dequeue (else zero) and the occupancy afterwards.
//   Requests are handled one at a time; s_ready is high only while the
//   controller is idle.
//   A swap on a non-empty queue reads every held entry before it finishes;
//   the scan reads the entry store one entry per cycle. A new request is
//   taken once the controller is back in idle after the result is
//   registered.
//   The result register lets a new request be taken while the previous
//   result still waits; a stalled receiver holds the finished request in its
//   last state until the result register frees up.
//   Reset (aresetn, synchronous, active low) empties the queue and drops any
//   pending result; the entry store itself is not cleared.
`default_nettype none

module fifo_with_value_swap_unit
    import fwvs_pkg::*;
#(
    parameter int DEPTH = FWVS_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire fwvs_in_t s_payload,
    output logic          m_valid,
    input  wire logic     m_ready,
    output fwvs_out_t     m_payload
);

    fwvs_cmd_t  cmd;
    fwvs_stat_t stat;

    // Sequence each request; hold in the finish state while the receiver stalls.
    fwvs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Hold pointers, count, entry store and the result register.
    fwvs_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_payload(s_payload),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

`default_nettype wire

[bench/fifo_with_value_swap_unit_tb.sv]
// Self-checking testbench for the FIFO with value swap: directed table, then random requests.
`timescale 1ns / 1ps

module fifo_with_value_swap_unit_tb
    import fwvs_pkg::*;
();

    localparam int    RANDOM_ITEMS = 1350;
    localparam int    CALM_ITEMS   = 150;    // final stretch with no new gaps or stall bursts on either side
    localparam int    DRAIN_CYCLES = 40;     // extra wait for any stray result
    localparam longint RUN_LIMIT_NS = 5_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        fwvs_in_t  req;
        bit        typed;
        fwvs_out_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    fwvs_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    fwvs_out_t m_payload;

    // Shadow copy of the queue, advanced on every accepted request.
    logic [DATA_W-1:0] shadow_store [FWVS_DEPTH];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_tail = 0;
    int unsigned       shadow_count = 0;

    fwvs_out_t due_results [$];
    dir_row_t  dir_rows [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    bit  calm = 1'b0;
    int  phase_mode = 0;
    int  stall_left = 0;
    int  ready_quiet = 0;
    int  tally_enq = 0, tally_deq = 0, tally_swap = 0, tally_unused = 0;
    int  tally_full = 0, tally_empty = 0, tally_missing = 0;

    fifo_with_value_swap_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout after %0d ns", RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one request to the shadow queue and return the result it owes.
    function automatic fwvs_out_t fifo_apply(fwvs_in_t req);
        fwvs_out_t   res;
        bit          hit_a, hit_b;
        int unsigned pos_a, pos_b, p;
        logic [DATA_W-1:0] held;
        res = '0;
        res.status = ST_OK;
        hit_a = 1'b0;
        hit_b = 1'b0;
        pos_a = 0;
        pos_b = 0;
        case (req.operation)
            OP_ENQUEUE: begin
                if (shadow_count >= FWVS_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = req.value;
                    shadow_tail = (shadow_tail + 1) % FWVS_DEPTH;
                    shadow_count++;
                end
            end
            OP_DEQUEUE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_value = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % FWVS_DEPTH;
                    shadow_count--;
                end
            end
            OP_SWAP: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // The last match from head to tail wins for each key.
                    for (int n = 0; n < shadow_count; n++) begin
                        p = (shadow_head + n) % FWVS_DEPTH;
                        if (shadow_store[p] == req.first_key) begin
                            hit_a = 1'b1;
                            pos_a = p;
                        end
                        if (shadow_store[p] == req.second_key) begin
                            hit_b = 1'b1;
                            pos_b = p;
                        end
                    end
                    if (hit_a && hit_b) begin
                        held = shadow_store[pos_a];
                        shadow_store[pos_a] = shadow_store[pos_b];
                        shadow_store[pos_b] = held;
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // Advance the shadow queue on a transfer and record what is owed for it.
    task automatic accept_request(fwvs_in_t req, bit typed, fwvs_out_t want);
        fwvs_out_t owed;
        owed = fifo_apply(req);
        due_results.push_back(typed ? want : owed);
        case (req.operation)
            OP_ENQUEUE: tally_enq++;
            OP_DEQUEUE: tally_deq++;
            OP_SWAP:    tally_swap++;
            default:    tally_unused++;
        endcase
        if (owed.status == ST_FULL)      tally_full++;
        if (owed.status == ST_EMPTY)     tally_empty++;
        if (owed.status == ST_NOT_FOUND) tally_missing++;
    endtask

    // Present one request, optionally after a gap or a full drain, and hold it until taken.
    task automatic send_request(fwvs_in_t req, int gap, bit drain, bit typed, fwvs_out_t want);
        if (gap > 0 || drain) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if (drain) begin
                do @(posedge aclk); while (due_results.size() != 0);
            end
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        accept_request(req, typed, want);
    endtask

    function automatic logic [DATA_W-1:0] held_value();
        if (shadow_count == 0 || $urandom_range(0, 4) == 0)
            return DATA_W'($urandom);
        return shadow_store[(shadow_head + $urandom_range(0, shadow_count - 1)) % FWVS_DEPTH];
    endfunction

    // Random request biased by the current phase: filling, draining or balanced.
    function automatic fwvs_in_t random_request();
        fwvs_in_t req;
        int       r;
        int       enq_pct, deq_pct;
        req.value      = DATA_W'($urandom);
        req.first_key  = DATA_W'($urandom);
        req.second_key = DATA_W'($urandom);
        case (phase_mode)
            0:       begin enq_pct = 60; deq_pct = 15; end
            1:       begin enq_pct = 15; deq_pct = 60; end
            default: begin enq_pct = 35; deq_pct = 35; end
        endcase
        // Keep values from a small alphabet often, so keys repeat in the queue.
        r = $urandom_range(0, 9);
        if (r < 4)
            req.value = DATA_W'($urandom_range(0, 5));
        else if (r == 4)
            req.value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            req.operation = OP_UNUSED;
        end else if (r < 2 + enq_pct) begin
            req.operation = OP_ENQUEUE;
        end else if (r < 2 + enq_pct + deq_pct) begin
            req.operation = OP_DEQUEUE;
        end else begin
            req.operation = OP_SWAP;
            if ($urandom_range(0, 9) < 8) begin
                req.first_key  = held_value();
                req.second_key = held_value();
            end
        end
        return req;
    endfunction

    task automatic add_row(logic [1:0] op, logic [7:0] val, logic [7:0] ka, logic [7:0] kb,
                           bit typed, logic [1:0] st, logic [7:0] rm, logic [4:0] occ);
        dir_row_t row;
        row.req.operation       = op;
        row.req.value           = val;
        row.req.first_key       = ka;
        row.req.second_key      = kb;
        row.typed               = typed;
        row.want.status         = st;
        row.want.removed_value  = rm;
        row.want.occupancy      = occ;
        dir_rows.push_back(row);
    endtask

    task automatic load_directed_table();
        // Refusals on an empty queue and the unused code.
        add_row(OP_DEQUEUE, 8'h00, 8'h00, 8'h00, 1, ST_EMPTY, 8'h00, 5'd0);
        add_row(OP_SWAP,    8'h00, 8'hFF, 8'h00, 1, ST_EMPTY, 8'h00, 5'd0);
        add_row(OP_UNUSED,  8'hFF, 8'hFF, 8'hFF, 1, ST_OK,    8'h00, 5'd0);
        // Fill to the brim: 00, FF, then 22..FF so FF sits twice.
        for (int i = 0; i < FWVS_DEPTH; i++) begin
            add_row(OP_ENQUEUE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 8'h11),
                    8'h00, 8'h00, 1, ST_OK, 8'h00, 5'(i + 1));
        end
        add_row(OP_ENQUEUE, 8'hA5, 8'h00, 8'h00, 1, ST_FULL,      8'h00, 5'd16);
        add_row(OP_SWAP,    8'h00, 8'h00, 8'hFF, 1, ST_OK,        8'h00, 5'd16);
        add_row(OP_SWAP,    8'h00, 8'h00, 8'h5A, 1, ST_NOT_FOUND, 8'h00, 5'd16);
        add_row(OP_SWAP,    8'h00, 8'h33, 8'h33, 1, ST_OK,        8'h00, 5'd16);
        // The head was touched by the swap: leave these to the predictor.
        add_row(OP_DEQUEUE, 8'h00, 8'h00, 8'h00, 0, ST_OK, 8'h00, 5'd0);
        add_row(OP_DEQUEUE, 8'h00, 8'h00, 8'h00, 0, ST_OK, 8'h00, 5'd0);
    endtask

    // Result side: random stall bursts, and the check against the oldest owed result.
    always @(posedge aclk) begin
        fwvs_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: %p", m_payload));
                end else begin
                    want = due_results.pop_front();
                    if (m_payload.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_payload.status, want.status));
                    if (m_payload.removed_value !== want.removed_value)
                        report_mismatch($sformatf("removed_value %02h, want %02h",
                                                  m_payload.removed_value, want.removed_value));
                    if (m_payload.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                                                  m_payload.occupancy, want.occupancy));
                end
            end
            // Decide the ready level for the next edge: one assignment per edge.
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (calm || ready_quiet > 0) begin
                if (ready_quiet > 0) ready_quiet--;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 49) == 0) ready_quiet = $urandom_range(50, 200);
                m_ready <= 1'b1;
            end
        end
    end

    // Request side: reset, directed table, random stream, drain and verdict.
    initial begin
        fwvs_in_t req;
        fwvs_out_t none;
        int counted;
        int gap;
        int quiet_left;
        int phase_left;
        bit drain;
        none = '0;
        counted = 0;
        quiet_left = 0;
        phase_left = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_directed_table();
        foreach (dir_rows[i]) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
            send_request(dir_rows[i].req, gap, 1'b0, dir_rows[i].typed, dir_rows[i].want);
        end

        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
            req = random_request();
            gap = 0;
            if (!calm) begin
                if (quiet_left > 0) begin
                    quiet_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    gap = $urandom_range(1, 13);
                end else if ($urandom_range(0, 39) == 0) begin
                    quiet_left = $urandom_range(30, 80);
                end
            end
            // Hold off until every owed result is back, once mid-run and now and then.
            drain = !calm && (counted == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0);
            send_request(req, gap, drain, 1'b0, none);
            if (req.operation != OP_UNUSED) counted++;
        end
        s_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("covered %0d enqueue, %0d dequeue, %0d swap, %0d unused-code transfers",
                 tally_enq, tally_deq, tally_swap, tally_unused);
        $display("refusals: %0d full, %0d empty, %0d key missing; %0d results checked",
                 tally_full, tally_empty, tally_missing, results_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
